// ===== sv/permutation_min_swaps_unit_assert.svh =====
// Assertion macros shared by the permutation minimum-swaps unit.
`ifndef PERMUTATION_MIN_SWAPS_UNIT_ASSERT_SVH
`define PERMUTATION_MIN_SWAPS_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PMS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define PMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/pms_pkg.sv =====
// Package with the payload types and sizing constants of the minimum-swaps unit.
package pms_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int VAL_W = 9;
  localparam int CMP_W = (VAL_W > CNT_W) ? VAL_W : CNT_W;

  typedef struct packed {
    logic [VAL_W-1:0] element_value;
    logic             last_element;
  } in_t;

  typedef struct packed {
    logic [7:0] swap_count;
    logic [8:0] cycle_count;
    logic       error_flag;
  } out_t;

endpackage

// ===== sv/permutation_min_swaps_unit.sv =====
// Permutation minimum-swaps unit: loads a permutation and counts its cycles.
//
// Usage: each input beat on in_data_i carries one 1-based permutation entry;
// the k-th beat of a set is the entry for position k. The beat whose
// last_element bit is set closes the set. For every closing beat exactly one
// result beat appears on out_data_o: the cycle count, the minimum number of
// swaps (entry count minus cycles) and an error flag. A zero value, a value
// above MAX_ELEMENTS or above the set length, or more than MAX_ELEMENTS
// entries make the set fail, and its result carries zero counts and the flag.
// Loading stores each entry of a set not yet rejected and clears the visited
// bit of the position it stores. After the closing beat the input is not
// ready while the walk runs. The map and visited stores share one read
// address and both reads are registered, so each position costs a fetch
// and a check in the scan and is met once more in a follow step, either
// along a cycle or as the step that closes one. The result step follows
// the walk, and the result beat becomes valid when the input is ready
// again. A rejected set skips the walk and goes straight to its result
// step. While the receiver stalls, the finished result holds in the output
// register and the next set loads; after its walk that set waits in its
// result step until the register is free. Reset empties the set and output.
`include "permutation_min_swaps_unit_assert.svh"

module permutation_min_swaps_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pms_pkg::out_t out_data_o
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SCHK   = 3'd2;
  localparam logic [2:0] S_FOLLOW = 3'd3;
  localparam logic [2:0] S_RES    = 3'd4;

  localparam int IDX_W = pms_pkg::IDX_W;
  localparam int CNT_W = pms_pkg::CNT_W;
  localparam int VAL_W = pms_pkg::VAL_W;
  localparam int CMP_W = pms_pkg::CMP_W;
  localparam int MAXE  = pms_pkg::MAX_ELEMENTS;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;      // entries stored in the current set
  logic             err_q, err_d;      // set already rejected
  logic [VAL_W-1:0] maxv_q, maxv_d;    // largest value stored so far
  logic [CNT_W-1:0] idx_q, idx_d;      // scan position of the walk
  logic [CNT_W-1:0] cyc_q, cyc_d;      // cycles found so far
  logic [IDX_W-1:0] pos_q, pos_d;      // position probed by the follow step
  logic             out_valid_q, out_valid_d;
  pms_pkg::out_t    out_data_q, out_data_d;

  // Map store: one write port for loading, one registered read port for the walk.
  logic [VAL_W-1:0] mem_q [MAXE];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] rd_data_q;

  // Visited store: read at the map read address, one write port. A write to
  // the address being read in the same cycle is passed straight through.
  logic             vis_mem_q [MAXE];
  logic             vis_we;
  logic [IDX_W-1:0] vis_waddr;
  logic             vis_wdata;
  logic             vis_rd_q;

  logic             in_accept;
  logic             val_bad;
  logic             set_full;
  logic [VAL_W-1:0] val_m1;
  logic [IDX_W-1:0] next_pos;

  assign in_ready_o  = (state_q == S_LOAD);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign val_bad  = (in_data_i.element_value == '0) ||
                    (CMP_W'(in_data_i.element_value) > CMP_W'(MAXE));
  assign set_full = (cnt_q == CNT_W'(MAXE));

  // Stored values are 1-based; the walk follows them as 0-based positions.
  assign val_m1   = rd_data_q - VAL_W'(1);
  assign next_pos = IDX_W'(val_m1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    maxv_d      = maxv_q;
    idx_d       = idx_q;
    cyc_d       = cyc_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IDX_W-1:0];
    mem_raddr   = idx_q[IDX_W-1:0];
    vis_we      = 1'b0;
    vis_waddr   = cnt_q[IDX_W-1:0];
    vis_wdata   = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          if (!err_q) begin
            if (set_full || val_bad) begin
              err_d = 1'b1;
            end else begin
              // Storing an entry also clears its visited bit for the coming walk.
              mem_we = 1'b1;
              vis_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
              if (in_data_i.element_value > maxv_q) begin
                maxv_d = in_data_i.element_value;
              end
            end
          end
          if (in_data_i.last_element) begin
            // A value above the set length means the map is no permutation.
            if (err_d || (CMP_W'(maxv_d) > CMP_W'(cnt_d))) begin
              err_d   = 1'b1;
              state_d = S_RES;
            end else begin
              idx_d   = '0;
              cyc_d   = '0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // The map entry and visited bit of the scan position are fetched here.
        if (idx_q == cnt_q) begin
          state_d = S_RES;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (vis_rd_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SCAN;
        end else begin
          cyc_d     = cyc_q + CNT_W'(1);
          vis_we    = 1'b1;
          vis_waddr = idx_q[IDX_W-1:0];
          vis_wdata = 1'b1;
          mem_raddr = next_pos;
          pos_d     = next_pos;
          state_d   = S_FOLLOW;
        end
      end
      S_FOLLOW: begin
        if (!vis_rd_q) begin
          vis_we    = 1'b1;
          vis_waddr = pos_q;
          vis_wdata = 1'b1;
          mem_raddr = next_pos;
          pos_d     = next_pos;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_data_d.swap_count  = '0;
            out_data_d.cycle_count = '0;
            out_data_d.error_flag  = 1'b1;
          end else begin
            out_data_d.swap_count  = 8'(cnt_q - cyc_q);
            out_data_d.cycle_count = 9'(cyc_q);
            out_data_d.error_flag  = 1'b0;
          end
          cnt_d   = '0;
          err_d   = 1'b0;
          maxv_d  = '0;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      maxv_q      <= '0;
      idx_q       <= '0;
      cyc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      maxv_q      <= maxv_d;
      idx_q       <= idx_d;
      cyc_q       <= cyc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_data_i.element_value;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem_q[vis_waddr] <= vis_wdata;
    end
    if (vis_we && (vis_waddr == mem_raddr)) begin
      vis_rd_q <= vis_wdata;
    end else begin
      vis_rd_q <= vis_mem_q[mem_raddr];
    end
  end

  `PMS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAXE), "entry count beyond store depth")
  `PMS_ASSERT_IMP(a_walk_clean, (state_q == S_SCAN) || (state_q == S_SCHK) || (state_q == S_FOLLOW), !err_q, "walk running on a rejected set")
  `PMS_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, (idx_q <= cnt_q) && (cyc_q <= idx_q), "scan position or cycle count out of bounds")
  `PMS_ASSERT_IMP(a_err_result, out_valid_o && out_data_o.error_flag, (out_data_o.swap_count == '0) && (out_data_o.cycle_count == '0), "rejected set returned nonzero counts")
  `PMS_ASSERT_IMP(a_res_source, out_valid_o && !$past(out_valid_o), $past(state_q) == S_RES, "result raised outside the result step")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the permutation minimum-swaps unit: directed and random sets, checked by a scoreboard.

class swap_scoreboard;
  logic [8:0]    perm_map [pms_pkg::MAX_ELEMENTS];
  int unsigned   loaded_cnt;
  bit            set_bad;
  pms_pkg::out_t pending_results[$];
  int unsigned   fail_cnt;
  int unsigned   beat_cnt;
  int unsigned   set_cnt;
  int unsigned   bad_set_cnt;
  int unsigned   checked_cnt;
  int unsigned   widest_set;
  int unsigned   most_cycles;

  function new();
    loaded_cnt  = 0;
    set_bad     = 1'b0;
    fail_cnt    = 0;
    beat_cnt    = 0;
    set_cnt     = 0;
    bad_set_cnt = 0;
    checked_cnt = 0;
    widest_set  = 0;
    most_cycles = 0;
    foreach (perm_map[i]) perm_map[i] = '0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Follows every cycle of the stored map; a fresh visited set per walk.
  function int unsigned count_cycles(int unsigned n);
    bit          seen [pms_pkg::MAX_ELEMENTS];
    int unsigned cycles;
    int unsigned p;
    cycles = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!seen[i]) begin
        cycles++;
        seen[i] = 1'b1;
        p = int'(perm_map[i]) - 1;
        while (p < n && !seen[p]) begin
          seen[p] = 1'b1;
          p = int'(perm_map[p]) - 1;
        end
      end
    end
    return cycles;
  endfunction

  // Called for every accepted input beat; a closing beat queues one result.
  function void note_input(pms_pkg::in_t beat);
    int unsigned   n;
    int unsigned   cycles;
    pms_pkg::out_t res;
    beat_cnt++;
    if (!set_bad) begin
      if (loaded_cnt >= pms_pkg::MAX_ELEMENTS) begin
        set_bad = 1'b1;
      end else if (beat.element_value == 0 || beat.element_value > pms_pkg::MAX_ELEMENTS) begin
        set_bad = 1'b1;
      end else begin
        perm_map[loaded_cnt] = beat.element_value;
        loaded_cnt++;
      end
    end
    if (!beat.last_element) return;
    n = loaded_cnt;
    if (!set_bad) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (perm_map[i] == 0 || perm_map[i] > n) set_bad = 1'b1;
      end
    end
    res = '0;
    if (set_bad) begin
      res.error_flag = 1'b1;
      bad_set_cnt++;
    end else begin
      cycles          = count_cycles(n);
      res.swap_count  = 8'(n - cycles);
      res.cycle_count = 9'(cycles);
      if (cycles > most_cycles) most_cycles = cycles;
    end
    if (n > widest_set) widest_set = n;
    set_cnt++;
    pending_results.push_back(res);
    loaded_cnt = 0;
    set_bad    = 1'b0;
  endfunction

  task report(string msg);
    if (fail_cnt < 40) $display("MISMATCH: %s", msg);
    fail_cnt++;
  endtask

  task check_result(pms_pkg::out_t got);
    pms_pkg::out_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result beat with nothing pending: swaps %0d cycles %0d err %0d",
                       got.swap_count, got.cycle_count, got.error_flag));
      return;
    end
    want = pending_results.pop_front();
    checked_cnt++;
    if (got.swap_count !== want.swap_count)
      report($sformatf("result %0d: swap_count %0d, want %0d",
                       checked_cnt, got.swap_count, want.swap_count));
    if (got.cycle_count !== want.cycle_count)
      report($sformatf("result %0d: cycle_count %0d, want %0d",
                       checked_cnt, got.cycle_count, want.cycle_count));
    if (got.error_flag !== want.error_flag)
      report($sformatf("result %0d: error_flag %0d, want %0d",
                       checked_cnt, got.error_flag, want.error_flag));
  endtask
endclass

module tb_top;

  // The slowest legal run is roughly 600 beats, each waiting out a long
  // sender gap, plus a walk per set and a long receiver stall per result.
  // The limit below leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 270;
  // Wait out more than the walk of the longest random set at the end
  // so a stray result beat still shows up.
  localparam int unsigned TAIL_CYCLES  = 600;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  pms_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  pms_pkg::out_t out_data_o;

  swap_scoreboard swap_sb = new();

  // When set, neither side inserts gaps, so beats run back to back.
  bit          quiet_mode;
  int unsigned cycle_cnt;
  int unsigned random_beats;
  int          set_vals[$];

  permutation_min_swaps_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Both monitors sample at the clock edge, before any of this edge's
  // nonblocking updates land, so they see exactly what the block saw.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) swap_sb.note_input(in_data_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) swap_sb.check_result(out_data_o);
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat after a random gap and holds it until accepted. With no
  // gap, valid stays high and only the payload changes.
  task automatic send_beat(int value, bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i                <= 1'b1;
    in_data_i.element_value   <= 9'(value);
    in_data_i.last_element    <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sends the staged values as one set, the final one marked last.
  task automatic send_set();
    foreach (set_vals[i]) send_beat(set_vals[i], i == set_vals.size() - 1);
    set_vals.delete();
  endtask

  // Uniform random permutation of 1..n.
  task automatic make_perm(int n);
    int j;
    int t;
    set_vals.delete();
    for (int i = 1; i <= n; i++) set_vals.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j           = $urandom_range(0, i);
      t           = set_vals[i];
      set_vals[i] = set_vals[j];
      set_vals[j] = t;
    end
  endtask

  // Random permutation that forms a single cycle through all n positions.
  task automatic make_cycle(int n);
    int j;
    int t;
    set_vals.delete();
    for (int i = 1; i <= n; i++) set_vals.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j           = $urandom_range(0, i - 1);
      t           = set_vals[i];
      set_vals[i] = set_vals[j];
      set_vals[j] = t;
    end
  endtask

  // The sender holds off until every result it caused has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (swap_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, then a ready window of random length that closes
  // on a result beat or when its length runs out, so stalls land on every phase.
  initial begin
    int unsigned gap;
    int unsigned win;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      win = $urandom_range(1, 8);
      do begin
        @(posedge clk_i);
        win--;
      end while (!out_valid_o && win > 0);
    end
  end

  initial begin
    int n;
    int r;
    int idx;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;
    quiet_mode  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets: smallest sets, a swap pair, a three-entry rotation, a
    // duplicate entry, a value beyond the set length, zero and all-ones values,
    // store-size and just-above values, and entries discarded after an error.
    set_vals = '{1};              send_set();
    set_vals = '{2, 1};           send_set();
    set_vals = '{2, 3, 1};        send_set();
    set_vals = '{1, 1};           send_set();
    set_vals = '{3, 1};           send_set();
    set_vals = '{0};              send_set();
    set_vals = '{511, 4, 2};      send_set();
    set_vals = '{257};            send_set();
    set_vals = '{2, 1, 0, 3};     send_set();
    set_vals = '{256};            send_set();
    drain_results();

    // Random sets, mostly small and well formed, some broken on purpose.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      quiet_mode = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 80)      n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 32);
      else             n = $urandom_range(33, 100);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        make_perm(n);
      end else if (r < 70) begin
        make_cycle(n);
      end else if (r < 78) begin
        // In range but usually not a permutation.
        set_vals.delete();
        repeat (n) set_vals.push_back($urandom_range(1, n));
      end else if (r < 86) begin
        // One entry points past the end of the set.
        make_perm(n);
        idx           = $urandom_range(0, n - 1);
        set_vals[idx] = $urandom_range(n + 1, pms_pkg::MAX_ELEMENTS);
      end else if (r < 93) begin
        // One entry is zero or beyond the store, the entries after it get discarded.
        make_perm(n);
        idx           = $urandom_range(0, n - 1);
        set_vals[idx] = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      end else begin
        set_vals.delete();
        repeat (n) set_vals.push_back($urandom_range(0, 511));
      end
      random_beats += n;
      send_set();
      if (random_beats > RANDOM_BEATS / 2 && random_beats - n <= RANDOM_BEATS / 2)
        drain_results();
    end
    quiet_mode = 1'b0;

    // One set with an entry too many: the store fills and the extra beat
    // rejects the set.
    set_vals.delete();
    repeat (pms_pkg::MAX_ELEMENTS + 1) set_vals.push_back($urandom_range(1, 256));
    send_set();

    in_valid_i <= 1'b0;
    while (swap_sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (swap_sb.pending() != 0)
      swap_sb.report($sformatf("%0d results never arrived", swap_sb.pending()));

    $display("Run covered %0d input beats in %0d sets, %0d rejected, %0d results checked.",
             swap_sb.beat_cnt, swap_sb.set_cnt, swap_sb.bad_set_cnt, swap_sb.checked_cnt);
    $display("Widest set held %0d entries; most cycles found in one set: %0d.",
             swap_sb.widest_set, swap_sb.most_cycles);
    if (swap_sb.fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
